### rtl/assert_macros.svh
// Assertion macros shared by the date adder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define DAD_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("date adder assertion failed");

// Same check on the usual clock and reset names.
`define DAD_ASSERT(label, prop) \
  `DAD_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

### rtl/dad_pkg.sv
// Package with widths, calendar functions and the controller/datapath bundles.
package dad_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DAYS_W  = 32;
  localparam int unsigned DOY_W   = 9;   // holds a day count up to 366
  localparam int unsigned M100_W  = 7;
  localparam int unsigned M400_W  = 9;

  // Year mod 400 is found by subtracting 400 shifted left by K_MAX down to 0.
  localparam int unsigned K_MAX = 5;
  localparam int unsigned K_W   = 3;

  localparam logic [MONTH_W-1:0] MI_FEB  = 4'd1;
  localparam logic [MONTH_W-1:0] MI_MAR  = 4'd2;
  localparam logic [MONTH_W-1:0] MI_DEC  = 4'd11;

  typedef struct packed {
    logic           load;
    logic           red;
    logic [K_W-1:0] red_k;
    logic           prep;
    logic           year_step;
    logic           month_step;
    logic           finish;
    logic           finish_ovf;
  } cmd_t;

  typedef struct packed {
    logic yr_over;
    logic fits;
    logic year_more;
    logic month_more;
  } sts_t;

  function automatic logic is_leap(input logic [1:0] m4, input logic [M100_W-1:0] m100,
                                   input logic [M400_W-1:0] m400);
    return ((m4 == 2'd0) && (m100 != '0)) || (m400 == '0);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mi,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    if (mi == MI_FEB) begin
      n = leap ? 5'd29 : 5'd28;
    end else if (mi inside {4'd3, 4'd5, 4'd8, 4'd10}) begin
      n = 5'd30;
    end else begin
      n = 5'd31;
    end
    return n;
  endfunction

  // Days of the year that lie before the first of month mi.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] mi,
                                                   input logic leap);
    logic [DOY_W-1:0] n;
    case (mi)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd59;
      4'd3:    n = 9'd90;
      4'd4:    n = 9'd120;
      4'd5:    n = 9'd151;
      4'd6:    n = 9'd181;
      4'd7:    n = 9'd212;
      4'd8:    n = 9'd243;
      4'd9:    n = 9'd273;
      4'd10:   n = 9'd304;
      default: n = 9'd334;
    endcase
    if (leap && (mi >= MI_MAR)) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

### rtl/dad_chan_if.sv
// Valid/ready channel interfaces for the start date and the result date.
interface dad_in_if;
  logic                        valid;
  logic                        ready;
  logic [dad_pkg::YEAR_W-1:0]  start_year;
  logic [dad_pkg::MONTH_W-1:0] start_month;
  logic [dad_pkg::DAY_W-1:0]   start_day;
  logic [dad_pkg::DAYS_W-1:0]  days_to_add;

  modport source (output valid, start_year, start_month, start_day, days_to_add,
                  input ready);
  modport sink (input valid, start_year, start_month, start_day, days_to_add,
                output ready);
endinterface

interface dad_out_if;
  logic                        valid;
  logic                        ready;
  logic [dad_pkg::YEAR_W-1:0]  result_year;
  logic [dad_pkg::MONTH_W-1:0] result_month;
  logic [dad_pkg::DAY_W-1:0]   result_day;
  logic                        overflow;

  modport source (output valid, result_year, result_month, result_day, overflow,
                  input ready);
  modport sink (input valid, result_year, result_month, result_day, overflow,
                output ready);
endinterface

### rtl/dad_datapath.sv
// Datapath: year, remainder and month registers with the calendar arithmetic.
`include "assert_macros.svh"

module dad_datapath #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dad_pkg::cmd_t               cmd_i,
  output dad_pkg::sts_t               sts_o,
  input  logic [dad_pkg::YEAR_W-1:0]  start_year_i,
  input  logic [dad_pkg::MONTH_W-1:0] start_month_i,
  input  logic [dad_pkg::DAY_W-1:0]   start_day_i,
  input  logic [dad_pkg::DAYS_W-1:0]  days_to_add_i,
  output logic [dad_pkg::YEAR_W-1:0]  result_year_o,
  output logic [dad_pkg::MONTH_W-1:0] result_month_o,
  output logic [dad_pkg::DAY_W-1:0]   result_day_o,
  output logic                        overflow_o
);

  localparam int unsigned YW_NEED = $clog2(MAX_YEAR + 2);
  localparam int unsigned YW = (YW_NEED > dad_pkg::YEAR_W) ? YW_NEED : dad_pkg::YEAR_W;
  localparam logic [YW-1:0] MAX_Y = YW'(MAX_YEAR);

  localparam int unsigned RW  = dad_pkg::YEAR_W;
  localparam int unsigned DW  = dad_pkg::DAYS_W;
  localparam int unsigned M1W = dad_pkg::M100_W;
  localparam int unsigned M4W = dad_pkg::M400_W;

  logic [YW-1:0]                 yr_q, yr_d;
  logic [DW-1:0]                 rem_q, rem_d;
  logic [DW-1:0]                 days_q, days_d;
  logic [dad_pkg::MONTH_W-1:0]   mi_q, mi_d;
  logic [dad_pkg::DAY_W-1:0]     day_q, day_d;
  logic [RW-1:0]                 red_q, red_d;
  logic [M1W-1:0]                m100_q, m100_d;
  logic [M4W-1:0]                m400_q, m400_d;
  logic [dad_pkg::YEAR_W-1:0]    res_year_q, res_year_d;
  logic [dad_pkg::MONTH_W-1:0]   res_month_q, res_month_d;
  logic [dad_pkg::DAY_W-1:0]     res_day_q, res_day_d;
  logic                          res_ovf_q, res_ovf_d;

  logic [RW-1:0]                 red_sub;
  logic [M4W-1:0]                s400;
  logic [M4W-1:0]                s100_w;
  logic [M1W-1:0]                s100;
  logic                          s_leap;
  logic [dad_pkg::DAY_W-1:0]     s_mlen;
  logic [dad_pkg::DAY_W-1:0]     s_day;
  logic [dad_pkg::DOY_W-1:0]     s_ylen;
  logic [dad_pkg::DOY_W-1:0]     s_left;
  logic [M1W-1:0]                s100_inc;
  logic [M4W-1:0]                s400_inc;
  logic                          c_leap;
  logic [dad_pkg::DOY_W-1:0]     c_ylen;
  logic [dad_pkg::DAY_W-1:0]     c_mlen;
  logic [M1W-1:0]                c100_inc;
  logic [M4W-1:0]                c400_inc;
  logic [dad_pkg::MONTH_W-1:0]   mi_load;

  // Start-year figures: red_q holds the year mod 400 once the reduction is done.
  always_comb begin
    red_sub = RW'(400) << cmd_i.red_k;
    s400    = red_q[M4W-1:0];
    if (s400 >= 9'd300) begin
      s100_w = s400 - 9'd300;
    end else if (s400 >= 9'd200) begin
      s100_w = s400 - 9'd200;
    end else if (s400 >= 9'd100) begin
      s100_w = s400 - 9'd100;
    end else begin
      s100_w = s400;
    end
    s100     = s100_w[M1W-1:0];
    s_leap   = dad_pkg::is_leap(yr_q[1:0], s100, s400);
    s_mlen   = dad_pkg::month_len(mi_q, s_leap);
    if (day_q == '0) begin
      s_day = 5'd1;
    end else if (day_q > s_mlen) begin
      s_day = s_mlen;
    end else begin
      s_day = day_q;
    end
    s_ylen   = s_leap ? 9'd366 : 9'd365;
    s_left   = s_ylen - dad_pkg::days_before(mi_q, s_leap) - dad_pkg::DOY_W'(s_day);
    s100_inc = (s100 == 7'd99) ? '0 : s100 + 7'd1;
    s400_inc = (s400 == 9'd399) ? '0 : s400 + 9'd1;
  end

  // Figures of the year currently held in yr_q.
  always_comb begin
    c_leap   = dad_pkg::is_leap(yr_q[1:0], m100_q, m400_q);
    c_ylen   = c_leap ? 9'd366 : 9'd365;
    c_mlen   = dad_pkg::month_len(mi_q, c_leap);
    c100_inc = (m100_q == 7'd99) ? '0 : m100_q + 7'd1;
    c400_inc = (m400_q == 9'd399) ? '0 : m400_q + 9'd1;
  end

  always_comb begin
    if (start_month_i == '0) begin
      mi_load = '0;
    end else if (start_month_i > 4'd12) begin
      mi_load = dad_pkg::MI_DEC;
    end else begin
      mi_load = start_month_i - 4'd1;
    end
  end

  always_comb begin
    sts_o.yr_over    = yr_q > MAX_Y;
    sts_o.fits       = days_q <= DW'(s_left);
    sts_o.year_more  = rem_q > DW'(c_ylen);
    sts_o.month_more = (mi_q < dad_pkg::MI_DEC) && (rem_q > DW'(c_mlen));
  end

  always_comb begin
    yr_d        = yr_q;
    rem_d       = rem_q;
    days_d      = days_q;
    mi_d        = mi_q;
    day_d       = day_q;
    red_d       = red_q;
    m100_d      = m100_q;
    m400_d      = m400_q;
    res_year_d  = res_year_q;
    res_month_d = res_month_q;
    res_day_d   = res_day_q;
    res_ovf_d   = res_ovf_q;
    if (cmd_i.load) begin
      yr_d   = YW'(start_year_i);
      red_d  = start_year_i;
      mi_d   = mi_load;
      day_d  = start_day_i;
      days_d = days_to_add_i;
    end
    if (cmd_i.red && (red_q >= red_sub)) begin
      red_d = red_q - red_sub;
    end
    if (cmd_i.prep) begin
      if (sts_o.fits) begin
        rem_d  = days_q + DW'(s_day);
        m100_d = s100;
        m400_d = s400;
      end else begin
        // The rest of the start year is used up; walk on from January 1.
        rem_d  = days_q - DW'(s_left);
        yr_d   = yr_q + YW'(1);
        mi_d   = '0;
        m100_d = s100_inc;
        m400_d = s400_inc;
      end
    end
    if (cmd_i.year_step) begin
      rem_d  = rem_q - DW'(c_ylen);
      yr_d   = yr_q + YW'(1);
      m100_d = c100_inc;
      m400_d = c400_inc;
    end
    if (cmd_i.month_step) begin
      rem_d = rem_q - DW'(c_mlen);
      mi_d  = mi_q + 4'd1;
    end
    if (cmd_i.finish) begin
      res_ovf_d = cmd_i.finish_ovf;
      if (cmd_i.finish_ovf) begin
        res_year_d  = '0;
        res_month_d = '0;
        res_day_d   = '0;
      end else begin
        res_year_d  = yr_q[dad_pkg::YEAR_W-1:0];
        res_month_d = mi_q + 4'd1;
        res_day_d   = rem_q[dad_pkg::DAY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    yr_q        <= yr_d;
    rem_q       <= rem_d;
    days_q      <= days_d;
    mi_q        <= mi_d;
    day_q       <= day_d;
    red_q       <= red_d;
    m100_q      <= m100_d;
    m400_q      <= m400_d;
    res_year_q  <= res_year_d;
    res_month_q <= res_month_d;
    res_day_q   <= res_day_d;
    res_ovf_q   <= res_ovf_d;
  end

  assign result_year_o  = res_year_q;
  assign result_month_o = res_month_q;
  assign result_day_o   = res_day_q;
  assign overflow_o     = res_ovf_q;

  `DAD_ASSERT(a_ovf_result_zero, cmd_i.finish && cmd_i.finish_ovf |=> overflow_o && (result_year_o == '0) && (result_month_o == '0) && (result_day_o == '0))
  `DAD_ASSERT(a_month_in_range, cmd_i.month_step |-> (mi_q < dad_pkg::MI_DEC))

endmodule

### rtl/dad_ctrl.sv
// Controller: sequences load, year reduction, set-up, year and month walks, result.
`include "assert_macros.svh"

module dad_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dad_pkg::cmd_t cmd_o,
  input  dad_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_PREP,
    ST_YEAR,
    ST_MONTH,
    ST_FIN
  } state_e;

  state_e                  state_q, state_d;
  logic [dad_pkg::K_W-1:0] k_q, k_d;
  logic                    ovf_q, ovf_d;
  logic                    out_valid_q, out_valid_d;
  logic                    slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o       = '0;
    cmd_o.red_k = k_q;
    state_d     = state_q;
    k_d         = k_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          k_d        = dad_pkg::K_W'(dad_pkg::K_MAX);
          state_d    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.red = 1'b1;
        if (k_q == '0) begin
          state_d = ST_PREP;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      ST_PREP: begin
        ovf_d = sts_i.yr_over;
        if (sts_i.yr_over) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.prep = 1'b1;
          state_d    = sts_i.fits ? ST_MONTH : ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sts_i.yr_over) begin
          ovf_d   = 1'b1;
          state_d = ST_FIN;
        end else if (sts_i.year_more) begin
          cmd_o.year_step = 1'b1;
        end else begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (sts_i.month_more) begin
          cmd_o.month_step = 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait until the result register is empty or is being read.
        if (slot_free) begin
          cmd_o.finish     = 1'b1;
          cmd_o.finish_ovf = ovf_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `DAD_ASSERT(a_no_result_overwrite, cmd_o.finish |-> (!out_valid_q || out_ready_i))
  `DAD_ASSERT(a_year_step_in_range, cmd_o.year_step |-> !sts_i.yr_over)
  `DAD_ASSERT(a_cmd_exclusive, $onehot0({cmd_o.load, cmd_o.red, cmd_o.prep, cmd_o.year_step, cmd_o.month_step, cmd_o.finish}))
  `DAD_ASSERT(a_finish_sets_valid, cmd_o.finish |=> out_valid_o)

endmodule

### rtl/date_add_days.sv
// Top level of the Gregorian date adder: controller, datapath and channel wiring.
//
// Adds a day count to a Gregorian date, one date at a time. A start date is taken
// when the block is idle. It then finds the start year modulo 400 by subtracting
// 400 shifted left by K_MAX down to 0, clamps the day and uses up the rest of the
// start year. Next it walks the whole years passed (at most MAX_YEAR), taking off
// one year length per cycle, then the months of the final year (at most eleven);
// a closing step ends each walk. A last step writes the result register. A date
// that fits in its start year skips the year walk, and an overflow found at the
// set-up step goes straight to the result write. The result waits in an output
// register. The last step stalls while that register still holds an unread beat.
// The next date is taken as soon as the previous result has been written there.
// An out-of-range month or day is clamped into range, and a result beyond
// MAX_YEAR comes back as overflow with all date fields zero.
module date_add_days #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input logic      clk_i,
  input logic      rst_ni,
  dad_in_if.sink   in_i,
  dad_out_if.source out_o
);

  dad_pkg::cmd_t cmd;
  dad_pkg::sts_t sts;

  dad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dad_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .start_year_i   (in_i.start_year),
    .start_month_i  (in_i.start_month),
    .start_day_i    (in_i.start_day),
    .days_to_add_i  (in_i.days_to_add),
    .result_year_o  (out_o.result_year),
    .result_month_o (out_o.result_month),
    .result_day_o   (out_o.result_day),
    .overflow_o     (out_o.overflow)
  );

endmodule

### bench/tb_date_add_days.sv
// Self-checking testbench for the Gregorian date adder with its own calendar predictor.
module tb_date_add_days;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_YEAR    = 9999;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 40;

  typedef struct packed {
    logic [dad_pkg::YEAR_W-1:0]  year;
    logic [dad_pkg::MONTH_W-1:0] month;
    logic [dad_pkg::DAY_W-1:0]   day;
    logic [dad_pkg::DAYS_W-1:0]  days;
  } start_date_t;

  typedef struct packed {
    logic [dad_pkg::YEAR_W-1:0]  year;
    logic [dad_pkg::MONTH_W-1:0] month;
    logic [dad_pkg::DAY_W-1:0]   day;
    logic                        ovf;
  } sum_date_t;

  logic clk_i;
  logic rst_ni;

  dad_in_if  in_if ();
  dad_out_if out_if ();

  date_add_days #(
    .MAX_YEAR(MAX_YEAR)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  start_date_t pending_dates[$];
  sum_date_t   expected_dates[$];
  start_date_t next_date;
  sum_date_t   want;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;
  int unsigned hold_left;
  int unsigned cycle_cnt;
  int unsigned budget;
  int unsigned dates_sent;
  int unsigned dates_checked;
  int unsigned overflow_seen;
  int unsigned mismatches;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // Month index mi counts from 0 for January.
  function automatic int unsigned days_in_month(input int unsigned mi, input int unsigned y);
    case (mi)
      1: begin
        return leap_year(y) ? 29 : 28;
      end
      3, 5, 8, 10: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // The offset is a 1-based day count from the first of month mi_first.
  function automatic void walk_months(input int unsigned mi_first, input longint unsigned offset,
                                      input int unsigned y, output int unsigned mo,
                                      output int unsigned dy);
    int unsigned      mi;
    longint unsigned  rest;
    mi   = mi_first;
    rest = offset;
    while (mi < 11 && rest > days_in_month(mi, y)) begin
      rest -= days_in_month(mi, y);
      mi++;
    end
    mo = mi + 1;
    dy = int'(rest);
  endfunction

  function automatic sum_date_t predict_date_sum(input start_date_t s);
    int unsigned     y;
    int unsigned     mi;
    int unsigned     dd;
    int unsigned     mo;
    int unsigned     dy;
    int unsigned     i;
    longint unsigned left;
    longint unsigned rest;
    bit              ovf;
    sum_date_t       r;
    y   = s.year;
    mi  = s.month;
    dd  = s.day;
    mo  = 0;
    dy  = 0;
    ovf = 1'b0;
    if (mi < 1) mi = 1;
    if (mi > 12) mi = 12;
    mi -= 1;
    if (dd < 1) dd = 1;
    if (dd > days_in_month(mi, y)) dd = days_in_month(mi, y);
    if (y > MAX_YEAR) begin
      ovf = 1'b1;
    end else begin
      left = 0;
      for (i = mi; i < 12; i++) left += days_in_month(i, y);
      left -= dd;
      if (longint'(s.days) <= left) begin
        walk_months(mi, longint'(s.days) + dd, y, mo, dy);
      end else begin
        // Use up the start year, then whole years, then months of the last year.
        rest = longint'(s.days) - left;
        y++;
        if (y > MAX_YEAR) ovf = 1'b1;
        while (!ovf && rest > (leap_year(y) ? 366 : 365)) begin
          rest -= leap_year(y) ? 366 : 365;
          y++;
          if (y > MAX_YEAR) ovf = 1'b1;
        end
        if (!ovf) walk_months(0, rest, y, mo, dy);
      end
    end
    r.ovf   = ovf;
    r.year  = ovf ? '0 : dad_pkg::YEAR_W'(y);
    r.month = ovf ? '0 : dad_pkg::MONTH_W'(mo);
    r.day   = ovf ? '0 : dad_pkg::DAY_W'(dy);
    return r;
  endfunction

  function automatic start_date_t random_start_date();
    start_date_t s;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      s.year = dad_pkg::YEAR_W'($urandom_range(16383, MAX_YEAR + 1));
    end else if (pick < 25) begin
      s.year = dad_pkg::YEAR_W'($urandom_range(MAX_YEAR, MAX_YEAR - 99));
    end else begin
      s.year = dad_pkg::YEAR_W'($urandom_range(MAX_YEAR, 0));
    end
    s.month = ($urandom_range(9) == 0) ? dad_pkg::MONTH_W'($urandom_range(15, 0))
                                       : dad_pkg::MONTH_W'($urandom_range(12, 1));
    s.day   = ($urandom_range(9) == 0) ? dad_pkg::DAY_W'($urandom_range(31, 0))
                                       : dad_pkg::DAY_W'($urandom_range(28, 1));
    // Mostly short spans keep the year walk brief; a few run to the top year.
    pick = $urandom_range(99);
    if (pick < 45) begin
      s.days = $urandom_range(400, 0);
    end else if (pick < 70) begin
      s.days = $urandom_range(40000, 0);
    end else if (pick < 88) begin
      s.days = $urandom_range(4000000, 0);
    end else begin
      s.days = $urandom();
    end
    return s;
  endfunction

  task automatic queue_date(input int unsigned y, input int unsigned m, input int unsigned d,
                            input logic [dad_pkg::DAYS_W-1:0] n);
    start_date_t s;
    int unsigned years;
    s.year  = dad_pkg::YEAR_W'(y);
    s.month = dad_pkg::MONTH_W'(m);
    s.day   = dad_pkg::DAY_W'(d);
    s.days  = n;
    years   = n / 365;
    if (years > MAX_YEAR + 2) years = MAX_YEAR + 2;
    budget += 340 + years;
    pending_dates.push_back(s);
  endtask

  task automatic queue_random(input int unsigned count);
    start_date_t s;
    repeat (count) begin
      s = random_start_date();
      queue_date(s.year, s.month, s.day, s.days);
    end
  endtask

  task automatic wait_drained();
    while (pending_dates.size() != 0 || in_if.valid || expected_dates.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender: a new beat is offered only once the current one has been taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.start_year  <= '0;
      in_if.start_month <= '0;
      in_if.start_day   <= '0;
      in_if.days_to_add <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        next_date.year  = in_if.start_year;
        next_date.month = in_if.start_month;
        next_date.day   = in_if.start_day;
        next_date.days  = in_if.days_to_add;
        expected_dates.push_back(predict_date_sum(next_date));
        dates_sent++;
      end
      if (pending_dates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_date = pending_dates.pop_front();
        in_if.valid       <= 1'b1;
        in_if.start_year  <= next_date.year;
        in_if.start_month <= next_date.month;
        in_if.start_day   <= next_date.day;
        in_if.days_to_add <= next_date.days;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (hold_req && hold_left == 0) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_if.ready <= !hold_req && hold_left <= 1 && $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_dates.size() == 0) begin
        $error("result beat with no date outstanding");
        mismatches++;
      end else begin
        want = expected_dates.pop_front();
        if (out_if.result_year !== want.year) begin
          $error("result_year: expected %0d, got %0d", want.year, out_if.result_year);
          mismatches++;
        end
        if (out_if.result_month !== want.month) begin
          $error("result_month: expected %0d, got %0d", want.month, out_if.result_month);
          mismatches++;
        end
        if (out_if.result_day !== want.day) begin
          $error("result_day: expected %0d, got %0d", want.day, out_if.result_day);
          mismatches++;
        end
        if (out_if.overflow !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, out_if.overflow);
          mismatches++;
        end
        if (want.ovf) overflow_seen++;
        dates_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3 * budget + 2 * HOLD_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    in_if.valid       = 1'b0;
    in_if.start_year  = '0;
    in_if.start_month = '0;
    in_if.start_day   = '0;
    in_if.days_to_add = '0;
    out_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    hold_req          = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    cycle_cnt         = 0;
    budget            = 5000;
    dates_sent        = 0;
    dates_checked     = 0;
    overflow_seen     = 0;
    mismatches        = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Leap rules, clamping of month and day, year and top-year edges.
    queue_date(0, 1, 1, 0);
    queue_date(0, 2, 29, 0);
    queue_date(1900, 2, 29, 0);
    queue_date(2000, 2, 30, 1);
    queue_date(2100, 2, 29, 0);
    queue_date(2023, 0, 0, 0);
    queue_date(2023, 15, 31, 0);
    queue_date(2023, 13, 5, 1);
    queue_date(2023, 12, 31, 1);
    queue_date(2024, 2, 28, 1);
    queue_date(2023, 2, 28, 1);
    queue_date(2024, 1, 1, 365);
    queue_date(2024, 1, 1, 366);
    queue_date(1999, 12, 31, 60);
    queue_date(1600, 3, 1, 306);
    queue_date(400, 4, 31, 30);
    queue_date(9999, 12, 31, 0);
    queue_date(9999, 12, 31, 1);
    queue_date(9998, 1, 1, 729);
    queue_date(9998, 1, 1, 730);
    queue_date(10000, 1, 1, 0);
    queue_date(16383, 15, 31, 32'hFFFF_FFFF);
    queue_date(0, 1, 1, 3652424);
    queue_date(0, 1, 1, 3652425);
    queue_date(0, 1, 1, 32'hFFFF_FFFF);
    wait_drained();

    // Back-to-back beats while the output is held off long enough to back up the input.
    queue_random(19);
    budget += HOLD_CYCLES;
    while (dates_sent < 27) @(negedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    hold_req = 1'b0;
    wait_drained();

    send_idle_pct = 78;
    queue_random(19);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 78;
    queue_random(19);
    wait_drained();

    send_idle_pct  = 12;
    recv_stall_pct = 12;
    queue_random(19);
    wait_drained();

    repeat (SETTLE) @(negedge clk_i);
    $display("Checked %0d sums (25 directed, 76 random), %0d of them overflows,",
             dates_checked, overflow_seen);
    $display("under free flow, sender gaps, receiver stalls and one long output hold.");
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
